// ----- design/sdtq_pkg.sv -----
// shared constants and types for the sorted deadline timer queue
package sdtq_pkg;
  localparam int unsigned TimerSlots = 16;
  localparam int unsigned SlotBits = $clog2(TimerSlots);
  localparam int unsigned CntBits = $clog2(TimerSlots + 1);
  localparam int unsigned TimeBits = 48;
  localparam int unsigned OutBits = 48;
  localparam int unsigned MaxFire = 16;

  localparam logic [1:0] FUNC_START = 2'd0;
  localparam logic [1:0] FUNC_CANCEL = 2'd1;
  localparam logic [1:0] FUNC_TICK = 2'd2;
  localparam logic [1:0] FUNC_QUERY = 2'd3;

  // commands from controller to datapath
  typedef struct packed {
    logic load;        // capture item, advance clock on tick
    logic unlink;      // remove slot from its list position
    logic find_step;   // walk one list entry
    logic find_clr;    // restart the walk
    logic insert;      // insert slot at found position
    logic pop;         // remove list head
    logic emit;        // drive a result
    logic emit_fired;  // result carries fired slot
    logic emit_last;
  } sdtq_cmd_t;

  // status from datapath to controller
  typedef struct packed {
    logic [1:0] func;
    logic       slot_ok;
    logic       was_active;
    logic       found;     // search position settled
    logic       head_due;  // list nonempty and head deadline reached
  } sdtq_stat_t;
endpackage

// ----- design/sorted_deadline_timer_queue_top.sv -----
// top level of the sorted deadline timer queue
// Raise start with an item while busy is low. A start walks the sorted list
// one entry per cycle to find its insertion point; a tick pops every due
// timer and gives one result item per fired timer (one item if none fired).
// Result items appear once per cycle on out_valid and must be taken when
// shown; out_last marks the final item of an operation.
module sorted_deadline_timer_queue_top (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  output logic        busy,
  input  logic [1:0]  in_func,
  input  logic [3:0]  in_timer_slot,
  input  logic [31:0] in_delay_ms,
  input  logic [15:0] in_tick_ms,
  output logic        out_valid,
  output logic        out_expired_valid,
  output logic [3:0]  out_expired_slot,
  output logic [47:0] out_next_timeout_ms,
  output logic [47:0] out_time_left_ms,
  output logic        out_last
);
  sdtq_pkg::sdtq_cmd_t  cmd;
  sdtq_pkg::sdtq_stat_t stat;

  assign out_valid = cmd.emit;

  sdtq_ctrl u_ctrl (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy), .stat(stat), .cmd(cmd)
  );

  sdtq_dp u_dp (
    .clk(clk), .rst_n(rst_n), .in_func(in_func), .in_timer_slot(in_timer_slot),
    .in_delay_ms(in_delay_ms), .in_tick_ms(in_tick_ms), .cmd(cmd), .stat(stat),
    .out_expired_valid(out_expired_valid), .out_expired_slot(out_expired_slot),
    .out_next_timeout_ms(out_next_timeout_ms), .out_time_left_ms(out_time_left_ms),
    .out_last(out_last)
  );
endmodule

// ----- design/sdtq_ctrl.sv -----
// controller state machine for the timer queue
module sdtq_ctrl (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                start,
  output logic                busy,
  input  sdtq_pkg::sdtq_stat_t stat,
  output sdtq_pkg::sdtq_cmd_t  cmd
);
  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_DISP = 3'd1;
  localparam logic [2:0] S_FIND = 3'd2;
  localparam logic [2:0] S_INS = 3'd3;
  localparam logic [2:0] S_POLL = 3'd4;
  localparam logic [2:0] S_DONE = 3'd5;

  logic [2:0] state_r, state_nxt;
  logic [4:0] fire_r, fire_nxt;

  assign busy = (state_r != S_IDLE);

  // next state and commands
  always_comb begin
    state_nxt = state_r;
    fire_nxt = fire_r;
    cmd = '0;
    unique case (state_r)
      S_IDLE: begin
        if (start) begin
          cmd.load = 1'b1;
          state_nxt = S_DISP;
        end
      end
      S_DISP: begin
        fire_nxt = '0;
        if (stat.func == sdtq_pkg::FUNC_TICK) begin
          state_nxt = S_POLL;
        end else if (stat.func == sdtq_pkg::FUNC_QUERY || !stat.slot_ok) begin
          state_nxt = S_DONE;
        end else begin
          cmd.unlink = stat.was_active;
          cmd.find_clr = 1'b1;
          state_nxt = (stat.func == sdtq_pkg::FUNC_START) ? S_FIND : S_DONE;
        end
      end
      S_FIND: begin
        if (stat.found) state_nxt = S_INS;
        else cmd.find_step = 1'b1;
      end
      S_INS: begin
        cmd.insert = 1'b1;
        state_nxt = S_DONE;
      end
      S_POLL: begin
        // pop one due head per cycle; result emitted once the next head is known
        if (stat.head_due && fire_r != 5'(sdtq_pkg::MaxFire)) begin
          cmd.pop = 1'b1;
          fire_nxt = fire_r + 5'd1;
        end else begin
          state_nxt = S_DONE;
        end
      end
      S_DONE: begin
        cmd.emit = 1'b1;
        cmd.emit_fired = (fire_r != '0);
        cmd.emit_last = (fire_r <= 5'd1);
        if (fire_r > 5'd1) fire_nxt = fire_r - 5'd1;
        else state_nxt = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      fire_r <= '0;
    end else begin
      state_r <= state_nxt;
      fire_r <= fire_nxt;
    end
  end

  a_one_cmd: assert property (@(posedge clk) disable iff (!rst_n)
    $onehot0({cmd.insert, cmd.pop, cmd.emit, cmd.load}))
    else $error("conflicting commands");
  a_emit_leaves: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.emit && cmd.emit_last) |=> !busy)
    else $error("last item did not end operation");
  a_fire_cap: assert property (@(posedge clk) disable iff (!rst_n)
    fire_r <= 5'(sdtq_pkg::MaxFire))
    else $error("fire count overflow");
endmodule

// ----- design/sdtq_dp.sv -----
// datapath: clock, deadlines, sorted slot list, fired queue and outputs
module sdtq_dp (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic [1:0]           in_func,
  input  logic [3:0]           in_timer_slot,
  input  logic [31:0]          in_delay_ms,
  input  logic [15:0]          in_tick_ms,
  input  sdtq_pkg::sdtq_cmd_t  cmd,
  output sdtq_pkg::sdtq_stat_t stat,
  output logic                 out_expired_valid,
  output logic [3:0]           out_expired_slot,
  output logic [47:0]          out_next_timeout_ms,
  output logic [47:0]          out_time_left_ms,
  output logic                 out_last
);
  localparam int unsigned N = sdtq_pkg::TimerSlots;
  localparam int unsigned SB = sdtq_pkg::SlotBits;
  localparam int unsigned CB = sdtq_pkg::CntBits;
  localparam int unsigned TB = sdtq_pkg::TimeBits;
  localparam int unsigned OB = sdtq_pkg::OutBits;
  localparam logic [TB-1:0] TMax = '1;

  logic [TB-1:0] now_r;
  logic [TB-1:0] dl_r [N];
  logic [N-1:0]  act_r;
  logic [SB-1:0] ord_r [N];
  logic [CB-1:0] cnt_r;
  logic [1:0]    func_r;
  logic [3:0]    slot_r;
  logic [31:0]   delay_r;
  logic [CB-1:0] pos_r;
  logic [TB-1:0] when_r;
  logic [SB-1:0] fq_r [sdtq_pkg::MaxFire];
  logic [4:0]    fwr_r, frd_r;

  logic [SB-1:0] sidx;
  logic          slot_ok;
  logic [TB:0]   tick_sum, dly_sum;
  logic [CB-1:0] upos;
  logic [TB-1:0] head_dl;
  logic          head_due;
  logic [TB-1:0] qdl;

  assign slot_ok = ({1'b0, slot_r} < 5'(N));
  assign sidx = slot_r[SB-1:0];
  assign tick_sum = {1'b0, now_r} + (TB+1)'(in_tick_ms);
  assign dly_sum = {1'b0, now_r} + (TB+1)'(delay_r);
  assign head_dl = dl_r[ord_r[0]];
  assign head_due = (cnt_r != '0) && (head_dl <= now_r);
  assign qdl = dl_r[sidx];

  // list position of the slot to unlink
  always_comb begin
    upos = '0;
    for (int i = 0; i < N; i++) begin
      if (ord_r[i] == sidx && CB'(i) < cnt_r) upos = CB'(i);
    end
  end

  assign stat.func = func_r;
  assign stat.slot_ok = slot_ok;
  assign stat.was_active = act_r[sidx];
  assign stat.found = (pos_r >= cnt_r) || (dl_r[ord_r[pos_r[SB-1:0]]] > when_r);
  assign stat.head_due = head_due;

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      now_r <= '0;
      act_r <= '0;
      cnt_r <= '0;
      fwr_r <= '0;
      frd_r <= '0;
    end else begin
      if (cmd.load) begin
        if (in_func == sdtq_pkg::FUNC_TICK)
          now_r <= tick_sum[TB] ? TMax : tick_sum[TB-1:0];
        fwr_r <= '0;
        frd_r <= '0;
      end
      if (cmd.unlink) begin
        act_r[sidx] <= 1'b0;
        cnt_r <= cnt_r - CB'(1);
      end
      if (cmd.insert) begin
        act_r[sidx] <= 1'b1;
        cnt_r <= cnt_r + CB'(1);
      end
      if (cmd.pop) begin
        act_r[ord_r[0]] <= 1'b0;
        cnt_r <= cnt_r - CB'(1);
        fwr_r <= fwr_r + 5'd1;
      end
      if (cmd.emit && cmd.emit_fired) frd_r <= frd_r + 5'd1;
    end
  end

  // payload registers: item capture, list shifts, search walk
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      func_r <= in_func;
      slot_r <= in_timer_slot;
      delay_r <= in_delay_ms;
    end
    if (cmd.find_clr) begin
      pos_r <= '0;
      when_r <= dly_sum[TB] ? TMax : dly_sum[TB-1:0];
    end
    if (cmd.find_step) pos_r <= pos_r + CB'(1);
    if (cmd.unlink) begin
      for (int i = 0; i < N - 1; i++)
        if (CB'(i) >= upos) ord_r[i] <= ord_r[i+1];
    end
    if (cmd.pop) begin
      for (int i = 0; i < N - 1; i++) ord_r[i] <= ord_r[i+1];
      fq_r[fwr_r[3:0]] <= ord_r[0];
    end
    if (cmd.insert) begin
      for (int i = 1; i < N; i++)
        if (CB'(i) > pos_r) ord_r[i] <= ord_r[i-1];
      ord_r[pos_r[SB-1:0]] <= sidx;
      dl_r[sidx] <= when_r;
    end
  end

  // result fields
  always_comb begin
    out_expired_valid = cmd.emit && cmd.emit_fired;
    out_expired_slot = out_expired_valid ? 4'(fq_r[frd_r[3:0]]) : 4'd0;
    out_last = cmd.emit && cmd.emit_last;
    out_next_timeout_ms = '0;
    out_time_left_ms = '0;
    if (cmd.emit) begin
      if (cmd.emit_fired && cnt_r == '0) out_next_timeout_ms = '0;
      if (cnt_r != '0) begin
        if (head_due) out_next_timeout_ms = OB'(1);
        else out_next_timeout_ms = OB'(head_dl - now_r);
      end
      if (func_r == sdtq_pkg::FUNC_QUERY && slot_ok && act_r[sidx] && qdl > now_r)
        out_time_left_ms = OB'(qdl - now_r);
    end
  end

  a_cnt_match: assert property (@(posedge clk) disable iff (!rst_n)
    32'($countones(act_r)) == 32'(cnt_r))
    else $error("active count mismatch");
  a_ins_room: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.insert |-> cnt_r < CB'(N))
    else $error("insert into full list");
  a_pop_due: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.pop |-> head_due)
    else $error("pop without due head");
endmodule
